// ===== sv/qlsc_pkg.sv =====
// Shared types and constants of the leaky-state classifier.
// No dependencies; the register, controller, datapath and top-level files import it.
`default_nettype none

package qlsc_pkg;

  // Number of state dimensions and the width of a dimension index
  localparam int DIMS  = 4096;
  localparam int DIM_W = $clog2(DIMS);
  localparam logic [DIM_W-1:0] DIM_LAST = DIM_W'(DIMS - 1);

  // State saturates to [-H_LIMIT, H_LIMIT]
  localparam logic [2:0] H_LIMIT = 3'd4;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_RATE   = 2'd0,
    OP_WEIGHT = 2'd1,
    OP_TOKEN  = 2'd2
  } op_t;

  // APB register map (word index taken from paddr[2])
  localparam int APB_ADDR_W = 3;
  localparam logic REG_SEQ_LEN = 1'b0;
  localparam logic REG_BIAS    = 1'b1;

  localparam logic [7:0] SEQ_LEN_RESET = 8'd16;

  // Configuration register contents
  typedef struct packed {
    logic [7:0]         seq_len;
    logic signed [15:0] bias;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic             wr_rate;    // write forget rate entry
    logic             wr_weight;  // write readout weight entry
    logic             start;      // token accepted: preset accumulator to bias
    logic             issue;      // read dimension addr and run it down the pipe
    logic             last;       // issued dimension is the final one
    logic             first;      // first token of a sequence: state reads as zero
    logic             tok;        // token identity
    logic [DIM_W-1:0] addr;       // dimension being issued
    logic             load_out;   // copy accumulator into the result register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic sweep_done;             // final dimension leaves the pipe this cycle
  } dp_status_t;

endpackage

`default_nettype wire

// ===== sv/qlsc_in_if.sv =====
// Input item channel: valid/ready handshake plus the item fields.
// No dependencies.
`default_nettype none

interface qlsc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [11:0]        dim_index;
  logic signed [15:0] table_value;
  logic               token;

  modport source (output valid, output operation, output dim_index,
                  output table_value, output token, input ready);
  modport sink   (input valid, input operation, input dim_index,
                  input table_value, input token, output ready);
endinterface

`default_nettype wire

// ===== sv/qlsc_out_if.sv =====
// Result item channel: valid/ready handshake plus class and logit.
// No dependencies.
`default_nettype none

interface qlsc_out_if;
  logic               valid;
  logic               ready;
  logic               predicted_class;
  logic signed [31:0] logit_value;

  modport source (output valid, output predicted_class, output logit_value,
                  input ready);
  modport sink   (input valid, input predicted_class, input logit_value,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/qlsc_regs.sv =====
// APB configuration registers: sequence length and readout bias.
// Depends on qlsc_pkg.
`default_nettype none

module qlsc_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [qlsc_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                      pwdata,
  output logic      [31:0]                      prdata,
  output logic                                  pready,
  output qlsc_pkg::cfg_t                        cfg
);
  import qlsc_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.seq_len <= SEQ_LEN_RESET;
      cfg.bias    <= '0;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_SEQ_LEN: cfg.seq_len <= pwdata[7:0];
        REG_BIAS:    cfg.bias    <= pwdata[15:0];
        default:     ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (paddr[2])
      REG_SEQ_LEN: prdata = {24'b0, cfg.seq_len};
      REG_BIAS:    prdata = {{16{cfg.bias[15]}}, cfg.bias};
      default:     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/qlsc_ctrl.sv =====
// Controller: input handshake, token counter, dimension sweep sequencer
// and result register valid. Depends on qlsc_pkg.
`default_nettype none

module qlsc_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            operation,
  input  wire logic                  token,
  input  wire logic [7:0]            seq_len,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output qlsc_pkg::dp_cmd_t          cmd,
  input  wire qlsc_pkg::dp_status_t  status
);
  import qlsc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SWEEP  = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

  state_t           state, state_next;
  logic [DIM_W-1:0] dim;
  logic [8:0]       token_count;
  logic [8:0]       count_inc;
  logic [8:0]       len_eff;
  logic             hit;
  logic             tok;
  logic             first;
  logic             readout;
  logic             accept;
  logic             tok_start;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign tok_start = accept && (operation == OP_TOKEN);

  // A zero length means 256 tokens
  assign len_eff   = (seq_len == 8'd0) ? 9'd256 : {1'b0, seq_len};
  assign count_inc = token_count + 9'd1;
  assign hit       = (count_inc >= len_eff);

  // Datapath commands
  always_comb begin
    cmd           = '0;
    cmd.wr_rate   = accept && (operation == OP_RATE);
    cmd.wr_weight = accept && (operation == OP_WEIGHT);
    cmd.start     = tok_start;
    cmd.issue     = (state == S_SWEEP);
    cmd.addr      = dim;
    cmd.last      = (dim == DIM_LAST);
    cmd.first     = first;
    cmd.tok       = tok;
    cmd.load_out  = (state == S_RESULT) && (!out_valid || out_ready);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (tok_start) state_next = S_SWEEP;
      S_SWEEP:  if (dim == DIM_LAST) state_next = S_DRAIN;
      S_DRAIN:  if (status.sweep_done) state_next = readout ? S_RESULT : S_IDLE;
      S_RESULT: if (cmd.load_out) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // State, counters and token flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      dim         <= '0;
      token_count <= '0;
      tok         <= 1'b0;
      first       <= 1'b0;
      readout     <= 1'b0;
    end else begin
      state <= state_next;
      if (tok_start) begin
        dim         <= '0;
        tok         <= token;
        first       <= (token_count == 9'd0);
        readout     <= hit;
        token_count <= hit ? 9'd0 : count_inc;
      end else if (state == S_SWEEP) begin
        dim <= dim + 1'b1;
      end
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== sv/qlsc_datapath.sv =====
// Datapath: forget rate, weight and state memories, the state update
// pipe, readout accumulator and result register.
// Depends on qlsc_pkg.
`default_nettype none

module qlsc_datapath (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire qlsc_pkg::dp_cmd_t     cmd,
  output qlsc_pkg::dp_status_t       status,
  input  wire logic [11:0]           dim_index,
  input  wire logic signed [15:0]    table_value,
  input  wire logic signed [15:0]    bias,
  output logic                       predicted_class,
  output logic signed [31:0]         logit_value
);
  import qlsc_pkg::*;

  // Memories
  logic [7:0]         rate_mem   [DIMS];
  logic signed [15:0] weight_mem [DIMS];
  logic signed [3:0]  state_mem  [DIMS];

  // Stage 1: registered memory data
  logic               s1_valid, s1_last, s1_first;
  logic [DIM_W-1:0]   s1_addr;
  logic signed [2:0]  s1_x;
  logic [7:0]         a_rd;
  logic signed [15:0] w_rd;
  logic signed [3:0]  h_rd;

  // Stage 2: updated state
  logic               s2_valid, s2_last;
  logic [DIM_W-1:0]   s2_addr;
  logic signed [3:0]  s2_h;
  logic signed [15:0] s2_w;

  logic signed [2:0]  x_issue;
  logic               wr_ok;
  logic signed [3:0]  h_old;
  logic signed [12:0] a_ext, b_ext, h_ext, x_ext, mix_n;
  logic [11:0]        mix_mag;
  logic [12:0]        mix_rnd;
  logic [2:0]         r_raw, r_sat;
  logic signed [3:0]  r_mag, h_new;
  logic signed [19:0] prod;
  logic signed [31:0] acc;

  assign wr_ok = ({20'b0, dim_index} < 32'(DIMS));

  // Token embedding for the issued dimension
  always_comb begin
    if (cmd.addr == DIM_W'(0)) begin
      x_issue = cmd.tok ? -3'sd3 : 3'sd3;
    end else if (cmd.addr == DIM_W'(1)) begin
      x_issue = cmd.tok ? 3'sd3 : -3'sd3;
    end else if (cmd.addr == DIM_W'(2)) begin
      x_issue = cmd.tok ? -3'sd1 : 3'sd1;
    end else begin
      x_issue = 3'sd0;
    end
  end

  // Table writes and stage 1 reads
  always_ff @(posedge clk) begin
    if (cmd.wr_rate && wr_ok) begin
      rate_mem[dim_index[DIM_W-1:0]] <= table_value[7:0];
    end
    if (cmd.issue) begin
      a_rd <= rate_mem[cmd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_weight && wr_ok) begin
      weight_mem[dim_index[DIM_W-1:0]] <= table_value;
    end
    if (cmd.issue) begin
      w_rd <= weight_mem[cmd.addr];
    end
  end

  // State memory: read at issue, written back from stage 2
  always_ff @(posedge clk) begin
    if (s2_valid) begin
      state_mem[s2_addr] <= s2_h;
    end
    if (cmd.issue) begin
      h_rd <= state_mem[cmd.addr];
    end
  end

  // Stage 1 control and side data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.issue;
    end
    s1_last  <= cmd.last;
    s1_first <= cmd.first;
    s1_addr  <= cmd.addr;
    s1_x     <= x_issue;
  end

  // Leaky mix: n = a*h + (256-a)*x, round half away from zero, clamp
  always_comb begin
    h_old   = s1_first ? 4'sd0 : h_rd;
    a_ext   = {5'b0, a_rd};
    b_ext   = 13'sd256 - a_ext;
    h_ext   = {{9{h_old[3]}}, h_old};
    x_ext   = {{10{s1_x[2]}}, s1_x};
    mix_n   = a_ext * h_ext + b_ext * x_ext;
    mix_mag = mix_n[12] ? 12'(-mix_n) : mix_n[11:0];
    mix_rnd = {1'b0, mix_mag} + 13'd128;
    r_raw   = mix_rnd[10:8];
    r_sat   = (r_raw > H_LIMIT) ? H_LIMIT : r_raw;
    r_mag   = {1'b0, r_sat};
    h_new   = mix_n[12] ? -r_mag : r_mag;
  end

  // Stage 2 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_last <= s1_last;
    s2_addr <= s1_addr;
    s2_h    <= h_new;
    s2_w    <= w_rd;
  end

  assign status.sweep_done = s2_valid && s2_last;

  // Readout accumulator, preset to the bias when a token starts
  assign prod = {{16{s2_h[3]}}, s2_h} * {{4{s2_w[15]}}, s2_w};

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc <= {{16{bias[15]}}, bias};
    end else if (s2_valid) begin
      acc <= acc + {{12{prod[19]}}, prod};
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      logit_value     <= acc;
      predicted_class <= !(acc > 32'sd0);
    end
  end

endmodule

`default_nettype wire

// ===== sv/quantized_leaky_state_classifier.sv =====
// Leaky-state classifier top level: a token item sweeps all DIMS dimensions
// (one dimension per cycle through the state memory, plus pipe fill and
// drain), and on the last token of a sequence the result register is then
// loaded once the output register is free.
// The next item is accepted while a result waits in its output register.
// Synchronous reset clears control and valid flags; first token reads state as zero.
`default_nettype none

module quantized_leaky_state_classifier (
  input  wire logic                            clk,
  input  wire logic                            rst,
  qlsc_in_if.sink                              cmd,
  qlsc_out_if.source                           result,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [qlsc_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready
);
  import qlsc_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  qlsc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  qlsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .operation (cmd.operation),
    .token     (cmd.token),
    .seq_len   (cfg.seq_len),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (dp_cmd),
    .status    (dp_status)
  );

  qlsc_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (dp_cmd),
    .status          (dp_status),
    .dim_index       (cmd.dim_index),
    .table_value     (cmd.table_value),
    .bias            (cfg.bias),
    .predicted_class (result.predicted_class),
    .logit_value     (result.logit_value)
  );

  // No item is taken while the sweep is issuing dimensions
  assert property (@(posedge clk) disable iff (rst) dp_cmd.issue |-> !cmd.ready)
    else $error("item accepted during a state sweep");

  // The pipe only finishes a sweep while the input side is held off
  assert property (@(posedge clk) disable iff (rst) dp_status.sweep_done |-> !cmd.ready)
    else $error("sweep finished while accepting items");

  // A pending result is never overwritten
  assert property (@(posedge clk) disable iff (rst)
    dp_cmd.load_out |-> (!result.valid || result.ready))
    else $error("result register overwritten before it was taken");

endmodule

`default_nettype wire
